### design/rtti_pkg.sv
// ----------------------------------------------------------------------------
// rtti_pkg: shared types and constants for the radix text-to-integer core
// Character codes, register indexes and the digit lookup result passed from
// the alphabet unit to the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rtti_pkg;

    localparam int BYTE_W     = 8;
    localparam int SYM_SLOTS  = 16;   // symbol slots held in configuration
    localparam int LEN_W      = 5;    // alphabet length, 0..16
    localparam int IDX_W      = 4;    // digit index, 0..15
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int OUT_W      = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic             alpha_ok;  // alphabet usable
        logic             hit;       // byte is a digit of the alphabet
        logic [IDX_W-1:0] index;     // digit value when hit
        logic [LEN_W-1:0] len;       // effective radix
    } digit_info_t;

endpackage

`default_nettype wire

### design/radix_text_to_integer_core.sv
// ----------------------------------------------------------------------------
// radix_text_to_integer_core: streaming text-to-integer in a configurable radix
// One byte per item in, one signed 32-bit value per string out.
// ----------------------------------------------------------------------------
// Takes one byte per item and parses it against a digit alphabet held in
// three configuration registers (symbol count, symbols 0-7, symbols 8-15,
// one byte each, low byte first). The radix is the lesser of the count,
// MAX_SYMBOLS and the position of the first zero symbol. Leading spaces,
// '+' and '-' are skipped, each '-' flipping the sign; digits then build
// acc*radix+digit, wrapping at VALUE_BITS. The first non-digit byte, or the
// NUL terminator, yields one result; bytes after that are dropped until NUL.
// An alphabet with fewer than two symbols, a sign symbol or a repeated
// symbol yields 0 for the string. Throughput is one item per cycle while
// the output is not stalled; the byte that ends the number is held first in
// the input register, and the parse step then loads the result register
// from it once the result register is free or being taken. The per-cycle
// path is the 16-way alphabet compare feeding a VALUE_BITS x 5 multiply-add.
// Write configuration only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_text_to_integer_core #(
    parameter int MAX_SYMBOLS = 16,
    parameter int VALUE_BITS  = 32
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration write port
    input  wire logic                               cfg_wr_en,
    input  wire logic [rtti_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rtti_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // text byte items
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [rtti_pkg::BYTE_W-1:0]        s_text_byte,
    // parsed value items
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [rtti_pkg::OUT_W-1:0]       m_value
);

    logic                          in_valid_reg;
    logic [rtti_pkg::BYTE_W-1:0]   in_byte_reg;
    logic                          take;
    logic [rtti_pkg::OUT_W-1:0]    res_value;
    rtti_pkg::digit_info_t         digit_info;

    // input register: refills in the same cycle its item is consumed
    assign s_ready = !in_valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_text_byte;
        end
    end

    // alphabet registers and digit lookup of the held byte
    rtti_alphabet #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_alphabet (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .lookup_byte (in_byte_reg),
        .digit_info  (digit_info)
    );

    // parse step and result register
    rtti_parser #(
        .VALUE_BITS (VALUE_BITS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (in_valid_reg),
        .item_byte  (in_byte_reg),
        .digit_info (digit_info),
        .take       (take),
        .res_valid  (m_valid),
        .res_ready  (m_ready),
        .res_value  (res_value)
    );

    assign m_value = $signed(res_value);

`ifndef NO_ASSERTIONS
    // a held byte that is not consumed stays put
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !take) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input register lost or changed an item");

    // an empty input register always accepts
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input register empty but not ready");

    // a new result only comes from a consumed byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(take))
        else $error("result appeared without a consumed item");
`endif

endmodule

`default_nettype wire

### design/rtti_alphabet.sv
// ----------------------------------------------------------------------------
// rtti_alphabet: digit alphabet registers and lookup
// Holds the configuration, derives the effective length and validity of the
// alphabet, and maps one byte to its digit value with a parallel compare.
// ----------------------------------------------------------------------------
`default_nettype none

module rtti_alphabet #(
    parameter int MAX_SYMBOLS = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [rtti_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rtti_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic [rtti_pkg::BYTE_W-1:0]        lookup_byte,
    output rtti_pkg::digit_info_t                   digit_info
);

    localparam int LEN_W = rtti_pkg::LEN_W;
    localparam int IDX_W = rtti_pkg::IDX_W;

    logic [LEN_W-1:0]                  symbol_count_reg;
    logic [rtti_pkg::CFG_DATA_W-1:0]   symbols_low_reg;
    logic [rtti_pkg::CFG_DATA_W-1:0]   symbols_high_reg;

    logic [rtti_pkg::BYTE_W-1:0] sym [rtti_pkg::SYM_SLOTS];
    logic [LEN_W-1:0]            lim;
    logic [LEN_W-1:0]            len;
    logic                        len_found;
    logic                        alpha_ok;
    logic                        hit;
    logic [IDX_W-1:0]            index;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            symbol_count_reg <= '0;
            symbols_low_reg  <= '0;
            symbols_high_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rtti_pkg::REG_SYMBOL_COUNT: symbol_count_reg <= cfg_wdata[LEN_W-1:0];
                rtti_pkg::REG_SYMBOLS_LOW:  symbols_low_reg  <= cfg_wdata;
                rtti_pkg::REG_SYMBOLS_HIGH: symbols_high_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < rtti_pkg::SYM_SLOTS; k++) begin
            if (k < 8) sym[k] = symbols_low_reg[8*k +: 8];
            else       sym[k] = symbols_high_reg[8*(k-8) +: 8];
        end
    end

    // effective length: min(count, MAX_SYMBOLS, first zero symbol)
    always_comb begin
        if (symbol_count_reg > LEN_W'(MAX_SYMBOLS)) lim = LEN_W'(MAX_SYMBOLS);
        else                                        lim = symbol_count_reg;
        len       = lim;
        len_found = 1'b0;
        for (int k = 0; k < rtti_pkg::SYM_SLOTS; k++) begin
            if (!len_found && (LEN_W'(k) < lim) && (sym[k] == rtti_pkg::CHAR_NUL)) begin
                len       = LEN_W'(k);
                len_found = 1'b1;
            end
        end
    end

    // validity: at least two symbols, no signs, no repeats
    always_comb begin
        alpha_ok = (len >= LEN_W'(2));
        for (int a = 0; a < rtti_pkg::SYM_SLOTS; a++) begin
            if (LEN_W'(a) < len) begin
                if ((sym[a] == rtti_pkg::CHAR_PLUS) || (sym[a] == rtti_pkg::CHAR_MINUS))
                    alpha_ok = 1'b0;
                for (int b = 0; b < a; b++) begin
                    if (sym[b] == sym[a]) alpha_ok = 1'b0;
                end
            end
        end
    end

    always_comb begin
        hit   = 1'b0;
        index = '0;
        for (int k = 0; k < rtti_pkg::SYM_SLOTS; k++) begin
            if (!hit && (LEN_W'(k) < len) && (sym[k] == lookup_byte)) begin
                hit   = 1'b1;
                index = IDX_W'(k);
            end
        end
    end

    assign digit_info.alpha_ok = alpha_ok;
    assign digit_info.hit      = hit;
    assign digit_info.index    = index;
    assign digit_info.len      = len;

endmodule

`default_nettype wire

### design/rtti_parser.sv
// ----------------------------------------------------------------------------
// rtti_parser: parse state, accumulator and result register
// Steps the sign/digit state machine one byte per cycle while the result is
// free or being taken, and holds a finished result until the output takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rtti_parser #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           item_valid,
    input  wire logic [rtti_pkg::BYTE_W-1:0]    item_byte,
    input  wire rtti_pkg::digit_info_t          digit_info,
    output logic                                take,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output logic [rtti_pkg::OUT_W-1:0]          res_value
);

    localparam logic [1:0] PH_SKIP  = 2'd0;  // spaces and signs
    localparam logic [1:0] PH_DIGS  = 2'd1;  // reading digits
    localparam logic [1:0] PH_DONE  = 2'd2;  // result given, wait for NUL
    localparam logic [1:0] PH_SPARE = 2'd3;  // never entered, acts as done

    localparam int LEN_W = rtti_pkg::LEN_W;
    localparam int IDX_W = rtti_pkg::IDX_W;

    logic [1:0]                 phase_reg, phase_next;
    logic                       neg_reg, neg_next;
    logic [VALUE_BITS-1:0]      acc_reg, acc_next;
    logic                       out_valid_reg, out_valid_next;
    logic [rtti_pkg::OUT_W-1:0] out_value_reg, out_value_next;

    logic                       advance;
    logic                       emit;
    logic                       is_nul;
    logic                       is_sign_or_space;
    logic [VALUE_BITS+LEN_W-1:0] prod_full;
    logic [VALUE_BITS-1:0]      acc_step;
    logic [VALUE_BITS-1:0]      result;
    logic [63:0]                result_wide;

    assign advance = !out_valid_reg || res_ready;
    assign take    = item_valid && advance;

    assign is_nul = (item_byte == rtti_pkg::CHAR_NUL);
    assign is_sign_or_space = (item_byte == rtti_pkg::CHAR_SPACE) ||
                              (item_byte == rtti_pkg::CHAR_PLUS)  ||
                              (item_byte == rtti_pkg::CHAR_MINUS);

    // acc * len + index, wrapping at VALUE_BITS
    assign prod_full = {{LEN_W{1'b0}}, acc_reg} * {{VALUE_BITS{1'b0}}, digit_info.len};
    assign acc_step  = prod_full[VALUE_BITS-1:0] +
                       {{(VALUE_BITS-IDX_W){1'b0}}, digit_info.index};

    assign result      = neg_reg ? (~acc_reg) + {{(VALUE_BITS-1){1'b0}}, 1'b1} : acc_reg;
    assign result_wide = 64'(result);

    always_comb begin
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        emit           = 1'b0;
        out_value_next = out_value_reg;

        if (take) begin
            if ((phase_reg == PH_DONE) || (phase_reg == PH_SPARE)) begin
                if (is_nul) phase_next = PH_SKIP;
            end else if (!digit_info.alpha_ok) begin
                emit           = 1'b1;
                out_value_next = '0;
                acc_next       = '0;
                neg_next       = 1'b0;
                phase_next     = is_nul ? PH_SKIP : PH_DONE;
            end else if ((phase_reg == PH_SKIP) && is_sign_or_space) begin
                // a space stays skipped here even if it is in the alphabet
                if (item_byte == rtti_pkg::CHAR_MINUS) neg_next = !neg_reg;
            end else if (digit_info.hit) begin
                acc_next   = acc_step;
                phase_next = PH_DIGS;
            end else begin
                emit           = 1'b1;
                out_value_next = result_wide[rtti_pkg::OUT_W-1:0];
                acc_next       = '0;
                neg_next       = 1'b0;
                phase_next     = is_nul ? PH_SKIP : PH_DONE;
            end
        end

        if (emit)           out_valid_next = 1'b1;
        else if (res_ready) out_valid_next = 1'b0;
        else                out_valid_next = out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SKIP;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_value_reg <= out_value_next;
    end

    assign res_valid = out_valid_reg;
    assign res_value = out_value_reg;

endmodule

`default_nettype wire
